[rtl/i2cm_pkg.sv]
// Shared types and constants for the I2C register-access master.
// No dependencies; the front end, back end and top-level files import this package.
package i2cm_pkg;

    // Action codes carried on the request channel
    localparam logic [1:0] ACTION_WRITE = 2'd0;
    localparam logic [1:0] ACTION_READ  = 2'd1;
    localparam logic [1:0] ACTION_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS      = 1'b0;
    localparam logic CFG_SEND_DEVICE_ADDRESS = 1'b1;

    localparam int CFG_DATA_W = 7;

    // Byte sequencing
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [1:0] STEP_DEV_WR   = 2'd0;
    localparam logic [1:0] STEP_REG      = 2'd1;
    localparam logic [1:0] STEP_SECOND   = 2'd2;
    localparam logic [1:0] STEP_READING  = 2'd3;

    // Classified request, as queued between front and back
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_cmd;

    // Configuration write, as handed to the bus engine
    typedef struct packed {
        logic                  wr_en;
        logic                  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

[rtl/i2cm_req_if.sv]
// Request channel: valid/ready handshake with the request payload.
// Depends on nothing but plain logic types.
interface i2cm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, action, reg_addr, write_data, sda_in, input ready);
    modport sink   (input valid, action, reg_addr, write_data, sda_in, output ready);
endinterface

[rtl/i2cm_res_if.sv]
// Result channel: valid/ready handshake with the bus and status payload.
// Depends on nothing but plain logic types.
interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       finished;
    logic       rejected;

    modport source (output valid, scl_level, sda_level, sda_enable, busy_res, read_byte,
                    finished, rejected, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_enable, busy_res, read_byte,
                    finished, rejected, output ready);
endinterface

[rtl/i2cm_front.sv]
// Front end: accepts requests, classifies the action and queues them.
// Depends on i2cm_pkg and i2cm_req_if.
module i2cm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    i2cm_req_if.sink        i_req,
    output i2cm_pkg::t_cmd  o_cmd,
    output logic            o_cmd_valid,
    input  logic            i_cmd_pop
);
    import i2cm_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       push, pop;
    t_cmd       cls;

    // Decode action into a command kind; undefined code is a no-op
    always_comb begin
        case (i_req.action)
            ACTION_WRITE: cls.kind = KIND_WRITE;
            ACTION_READ:  cls.kind = KIND_READ;
            ACTION_TICK:  cls.kind = KIND_TICK;
            default:      cls.kind = KIND_NOP;
        endcase
        cls.reg_addr    = i_req.reg_addr;
        cls.write_data  = i_req.write_data;
        cls.sda_in      = i_req.sda_in;
    end

    assign i_req.ready = (r_count != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_slot[r_rd_ptr];

    // Two-entry queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= cls;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

[rtl/i2cm_back.sv]
// Back end: I2C bus sequencer, configuration registers and result register.
// Depends on i2cm_pkg and i2cm_res_if.
module i2cm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  i2cm_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    input  i2cm_pkg::t_cfg_wr i_cfg,
    i2cm_res_if.source        o_res
);
    import i2cm_pkg::*;

    typedef enum logic [20:0] {
        PH_IDLE   = 21'h000001,
        PH_ST0    = 21'h000002,
        PH_ST1    = 21'h000004,
        PH_ST2    = 21'h000008,
        PH_TX_LO  = 21'h000010,
        PH_TX_DAT = 21'h000020,
        PH_TX_HI  = 21'h000040,
        PH_AK_LO  = 21'h000080,
        PH_AK_DAT = 21'h000100,
        PH_AK_HI  = 21'h000200,
        PH_AK_END = 21'h000400,
        PH_RD_LO  = 21'h000800,
        PH_RD_HI  = 21'h001000,
        PH_RD_SMP = 21'h002000,
        PH_NK_LO  = 21'h004000,
        PH_NK_DAT = 21'h008000,
        PH_NK_HI  = 21'h010000,
        PH_NK_END = 21'h020000,
        PH_SP0    = 21'h040000,
        PH_SP1    = 21'h080000,
        PH_SP2    = 21'h100000
    } t_phase;

    logic [6:0] r_dev_addr;
    logic       r_send_dev;

    t_phase     r_phase, n_phase;
    logic       r_is_read, n_is_read;
    logic [1:0] r_byte_step, n_byte_step;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_held_addr, n_held_addr;
    logic [7:0] r_held_data, n_held_data;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;

    logic       done, rej, released;

    // Result register, refilled from a queued command whenever empty or being taken
    logic       r_out_valid;
    logic       r_o_scl, r_o_sda, r_o_en, r_o_busy, r_o_fin, r_o_rej;
    logic [7:0] r_o_byte;

    assign o_cmd_pop = i_cmd_valid && (!r_out_valid || o_res.ready);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 7'd0;
            r_send_dev <= 1'b1;
        end else if (i_cfg.wr_en) begin
            case (i_cfg.index)
                CFG_DEVICE_ADDRESS:      r_dev_addr <= i_cfg.data;
                CFG_SEND_DEVICE_ADDRESS: r_send_dev <= i_cfg.data[0];
                default:                 r_dev_addr <= r_dev_addr;
            endcase
        end
    end

    // Next state for one queued command
    always_comb begin
        n_phase     = r_phase;
        n_is_read   = r_is_read;
        n_byte_step = r_byte_step;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_held_addr = r_held_addr;
        n_held_data = r_held_data;
        n_scl       = r_scl;
        n_sda       = r_sda;
        done        = 1'b0;
        rej         = 1'b0;

        case (i_cmd.kind)
            KIND_WRITE, KIND_READ: begin
                if (r_phase != PH_IDLE) begin
                    rej = 1'b1;
                end else begin
                    n_is_read   = (i_cmd.kind == KIND_READ);
                    n_held_addr = i_cmd.reg_addr;
                    if (i_cmd.kind == KIND_WRITE) n_held_data = i_cmd.write_data;
                    n_byte_step = STEP_DEV_WR;
                    n_bit_count = 4'd0;
                    n_phase     = PH_ST0;
                end
            end
            KIND_TICK: begin
                case (r_phase)
                    PH_IDLE: ;
                    PH_ST0: begin n_sda = 1'b1; n_phase = PH_ST1; end
                    PH_ST1: begin n_scl = 1'b1; n_phase = PH_ST2; end
                    PH_ST2: begin
                        n_sda       = 1'b0;
                        n_bit_count = 4'd0;
                        n_phase     = PH_TX_LO;
                        if (r_is_read && r_byte_step == STEP_SECOND) begin
                            n_shift     = {r_dev_addr, 1'b1};
                            n_byte_step = STEP_SECOND;
                        end else if (r_send_dev) begin
                            n_shift     = {r_dev_addr, 1'b0};
                            n_byte_step = STEP_DEV_WR;
                        end else begin
                            n_shift     = r_held_addr;
                            n_byte_step = STEP_REG;
                        end
                    end
                    PH_TX_LO:  begin n_scl = 1'b0; n_phase = PH_TX_DAT; end
                    PH_TX_DAT: begin n_sda = r_shift[7]; n_phase = PH_TX_HI; end
                    PH_TX_HI: begin
                        n_scl       = 1'b1;
                        n_shift     = {r_shift[6:0], 1'b0};
                        n_bit_count = r_bit_count + 4'd1;
                        n_phase     = (n_bit_count >= BITS_PER_BYTE) ? PH_AK_LO : PH_TX_LO;
                    end
                    PH_AK_LO:  begin n_scl = 1'b0; n_phase = PH_AK_DAT; end
                    PH_AK_DAT: begin n_sda = 1'b0; n_phase = PH_AK_HI; end
                    PH_AK_HI:  begin n_scl = 1'b1; n_phase = PH_AK_END; end
                    PH_AK_END: begin
                        // Pick the next byte, a repeated start, the read or the stop once the acknowledge clock ends
                        n_scl = 1'b0;
                        if (r_byte_step == STEP_DEV_WR) begin
                            n_shift     = r_held_addr;
                            n_byte_step = STEP_REG;
                            n_bit_count = 4'd0;
                            n_phase     = PH_TX_LO;
                        end else if (r_byte_step == STEP_REG && !r_is_read) begin
                            n_shift     = r_held_data;
                            n_byte_step = STEP_SECOND;
                            n_bit_count = 4'd0;
                            n_phase     = PH_TX_LO;
                        end else if (r_byte_step == STEP_REG && r_send_dev) begin
                            n_byte_step = STEP_SECOND;
                            n_phase     = PH_ST0;
                        end else if ((r_byte_step == STEP_REG) ||
                                     (r_byte_step == STEP_SECOND && r_is_read)) begin
                            n_shift     = 8'd0;
                            n_bit_count = 4'd0;
                            n_byte_step = STEP_READING;
                            n_sda       = 1'b1;
                            n_phase     = PH_RD_LO;
                        end else begin
                            n_phase = PH_SP0;
                        end
                    end
                    PH_RD_LO: begin n_scl = 1'b0; n_phase = PH_RD_HI; end
                    PH_RD_HI: begin n_scl = 1'b1; n_phase = PH_RD_SMP; end
                    PH_RD_SMP: begin
                        n_shift     = {r_shift[6:0], i_cmd.sda_in};
                        n_bit_count = r_bit_count + 4'd1;
                        n_phase     = (n_bit_count >= BITS_PER_BYTE) ? PH_NK_LO : PH_RD_LO;
                    end
                    PH_NK_LO:  begin n_scl = 1'b0; n_phase = PH_NK_DAT; end
                    PH_NK_DAT: begin n_sda = 1'b1; n_phase = PH_NK_HI; end
                    PH_NK_HI:  begin n_scl = 1'b1; n_phase = PH_NK_END; end
                    PH_NK_END: begin n_scl = 1'b0; n_phase = PH_SP0; end
                    PH_SP0:    begin n_sda = 1'b0; n_phase = PH_SP1; end
                    PH_SP1:    begin n_scl = 1'b1; n_phase = PH_SP2; end
                    PH_SP2: begin
                        n_sda   = 1'b1;
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                    default: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign released = (n_phase == PH_RD_LO) || (n_phase == PH_RD_HI) ||
                      (n_phase == PH_RD_SMP) || (n_phase == PH_NK_LO);

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_is_read   <= 1'b0;
            r_byte_step <= STEP_DEV_WR;
            r_bit_count <= 4'd0;
            r_shift     <= 8'd0;
            r_held_addr <= 8'd0;
            r_held_data <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
        end else if (o_cmd_pop) begin
            r_phase     <= n_phase;
            r_is_read   <= n_is_read;
            r_byte_step <= n_byte_step;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_held_addr <= n_held_addr;
            r_held_data <= n_held_data;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_o_scl  <= n_scl;
            r_o_sda  <= n_sda;
            r_o_en   <= !released;
            r_o_busy <= (n_phase != PH_IDLE);
            r_o_byte <= (n_is_read && n_byte_step == STEP_READING) ? n_shift : 8'd0;
            r_o_fin  <= done;
            r_o_rej  <= rej;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.scl_level  = r_o_scl;
    assign o_res.sda_level  = r_o_sda;
    assign o_res.sda_enable = r_o_en;
    assign o_res.busy_res   = r_o_busy;
    assign o_res.read_byte  = r_o_byte;
    assign o_res.finished   = r_o_fin;
    assign o_res.rejected   = r_o_rej;
endmodule

[rtl/i2c_master_register_access.sv]
// I2C master for single-register write and read transactions. Every request
// (write, read or half-period tick) gives exactly one result, and the block
// takes one request per clock cycle while results are taken: a request is
// decoded and stored in the front queue, then the bus sequencer takes it and
// its result lands in an output register. The two-entry queue lets requests
// keep coming while a result waits. Write configuration only while no requests
// are in flight.
module i2c_master_register_access (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    i2cm_req_if.sink                       i_req,
    i2cm_res_if.source                     o_res,
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import i2cm_pkg::*;

    t_cmd    cmd;
    logic    cmd_valid;
    logic    cmd_pop;
    t_cfg_wr cfg;

    assign cfg.wr_en = i_cfg_wr_en;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    i2cm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    i2cm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (cfg),
        .o_res       (o_res)
    );

    // The sequencer only takes queued requests
    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("queue popped while empty");

    // Every processed request shows up as a result next cycle
    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |=> o_res.valid)
        else $error("processed request produced no result");

    // A completed stop leaves the bus idle
    a_finish_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.finished) |-> !o_res.busy_res)
        else $error("finished reported while busy");

    // Requests are only dropped during a transaction
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.rejected) |-> o_res.busy_res)
        else $error("request rejected while idle");
endmodule
